// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the merging stage of the two-button press classifier
// depends on nothing; define ASSERT_OFF to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every rising edge out of reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// condition must never be seen at a rising edge out of reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ----- hw/rtl/tbpc_pkg.sv -----
// shared types and constants of the two-button press classifier
// depends on nothing
`default_nettype none

package tbpc_pkg;

    // event codes carried on the result channel
    typedef enum logic [1:0] {
        EV_SHORT_ONE = 2'd0,
        EV_SHORT_TWO = 2'd1,
        EV_LONG      = 2'd2,
        EV_COMBO     = 2'd3
    } event_code_t;

    // configuration register indexes
    localparam logic CFG_DEBOUNCE = 1'b0;
    localparam logic CFG_HOLD     = 1'b1;

    localparam int CFG_W = 16;

    // what one button lane found for the current item
    typedef struct packed {
        logic short_hit;
        logic long_hit;
    } lane_hit_t;

    // one queued result
    typedef struct packed {
        logic        last;
        event_code_t code;
    } out_item_t;

    // result queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

endpackage

`default_nettype wire

// ----- hw/rtl/tbpc_lane.sv -----
// one button lane: debounce, short press and long press for a single button
// depends on tbpc_pkg
`default_nettype none

module tbpc_lane #(
    parameter int TIME_BITS = 32
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            en,
    input  wire  [TIME_BITS-1:0]           now,
    input  wire                            raw,
    input  wire  [tbpc_pkg::CFG_W-1:0]     debounce_ms,
    input  wire  [tbpc_pkg::CFG_W-1:0]     hold_ms,
    output tbpc_pkg::lane_hit_t            hit
);

    logic                 prev_reg,   prev_next;
    logic                 stable_reg, stable_next;
    logic                 long_reg,   long_next;
    logic [TIME_BITS-1:0] change_reg, change_next;
    logic [TIME_BITS-1:0] press_reg,  press_next;

    logic                 changed;
    logic                 flip;
    logic                 pressed;
    logic                 released;
    logic                 long_eff;
    logic                 hold_ok;
    logic                 short_w;
    logic                 long_w;
    logic [TIME_BITS-1:0] since_change;
    logic [TIME_BITS-1:0] since_press;
    logic [TIME_BITS-1:0] debounce_ext;
    logic [TIME_BITS-1:0] hold_ext;

    assign debounce_ext = TIME_BITS'(debounce_ms);
    assign hold_ext     = TIME_BITS'(hold_ms);
    assign since_change = now - change_reg;
    assign since_press  = now - press_reg;

    always_comb begin
        // a level that changes on this item has zero age and cannot be stable yet
        changed     = (raw != prev_reg);
        flip        = !changed && (since_change > debounce_ext) && (raw != stable_reg);
        pressed     = flip && !raw;
        released    = flip && raw;
        short_w     = released && !long_reg;
        stable_next = flip ? raw : stable_reg;
        long_eff    = pressed ? 1'b0 : long_reg;
        // a fresh press has zero age
        hold_ok     = pressed ? (hold_ms == '0) : (since_press >= hold_ext);
        long_w      = !stable_next && !long_eff && hold_ok;
        long_next   = long_w | long_eff;
        prev_next   = raw;
        change_next = changed ? now : change_reg;
        press_next  = pressed ? now : press_reg;
    end

    assign hit.short_hit = en && short_w;
    assign hit.long_hit  = en && long_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg   <= 1'b1;
            stable_reg <= 1'b1;
            long_reg   <= 1'b0;
            change_reg <= '0;
            press_reg  <= '0;
        end else if (en) begin
            prev_reg   <= prev_next;
            stable_reg <= stable_next;
            long_reg   <= long_next;
            change_reg <= change_next;
            press_reg  <= press_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tbpc_combo.sv -----
// combo timer: both buttons held together for the hold time
// depends on tbpc_pkg
`default_nettype none

module tbpc_combo #(
    parameter int TIME_BITS = 32
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            en,
    input  wire                            both_low,
    input  wire  [TIME_BITS-1:0]           now,
    input  wire  [tbpc_pkg::CFG_W-1:0]     hold_ms,
    output logic                           combo_hit
);

    logic                 running_reg,  running_next;
    logic                 reported_reg, reported_next;
    logic [TIME_BITS-1:0] start_reg,    start_next;

    logic                 rep_eff;
    logic                 hold_ok;
    logic                 fire;
    logic [TIME_BITS-1:0] since_start;

    assign since_start = now - start_reg;

    always_comb begin
        rep_eff = running_reg ? reported_reg : 1'b0;
        // a combo that starts on this item has zero age
        hold_ok = running_reg ? (since_start >= TIME_BITS'(hold_ms)) : (hold_ms == '0);
        fire    = both_low && !rep_eff && hold_ok;
        if (both_low) begin
            running_next  = 1'b1;
            start_next    = running_reg ? start_reg : now;
            reported_next = rep_eff | fire;
        end else begin
            running_next  = 1'b0;
            start_next    = start_reg;
            reported_next = 1'b0;
        end
    end

    assign combo_hit = en && fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg  <= 1'b0;
            reported_reg <= 1'b0;
        end else if (en) begin
            running_reg  <= running_next;
            reported_reg <= reported_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            start_reg <= start_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tbpc_merge.sv -----
// merging stage: orders lane and combo events and queues them for the output
// depends on tbpc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module tbpc_merge (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   push,
    input  wire                   combo_hit,
    input  tbpc_pkg::lane_hit_t   hit_one,
    input  tbpc_pkg::lane_hit_t   hit_two,
    output logic                  room,
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [7:0]            m_tdata,    // [1:0] event_code, rest zero
    output logic                  m_tlast
);

    tbpc_pkg::out_item_t           q_reg [tbpc_pkg::QDEPTH];
    logic [tbpc_pkg::QPTR_W-1:0]   wr_reg, wr_next;
    logic [tbpc_pkg::QPTR_W-1:0]   rd_reg, rd_next;
    logic [tbpc_pkg::QCNT_W-1:0]   cnt_reg, cnt_next;

    logic                          any_one;
    logic                          any_two;
    tbpc_pkg::event_code_t         code_one;
    tbpc_pkg::event_code_t         code_two;
    tbpc_pkg::out_item_t           item_a;
    tbpc_pkg::out_item_t           item_b;
    logic [1:0]                    n_items;
    logic                          pop;
    logic [tbpc_pkg::QPTR_W-1:0]   wr_plus;
    tbpc_pkg::out_item_t           head;

    // helpers for the checks below
    logic                          lane_clash;
    logic                          grow_only;
    logic [tbpc_pkg::QCNT_W-1:0]   cnt_grown;

    always_comb begin
        any_one  = hit_one.short_hit | hit_one.long_hit;
        any_two  = hit_two.short_hit | hit_two.long_hit;
        code_one = hit_one.short_hit ? tbpc_pkg::EV_SHORT_ONE : tbpc_pkg::EV_LONG;
        code_two = hit_two.short_hit ? tbpc_pkg::EV_SHORT_TWO : tbpc_pkg::EV_LONG;
        item_b.code = code_two;
        item_b.last = 1'b1;
        if (combo_hit) begin
            n_items     = 2'd1;
            item_a.code = tbpc_pkg::EV_COMBO;
            item_a.last = 1'b1;
        end else begin
            // button one first, then button two
            n_items     = 2'({1'b0, any_one} + {1'b0, any_two});
            item_a.code = any_one ? code_one : code_two;
            item_a.last = !(any_one && any_two);
        end
        if (!push) begin
            n_items = 2'd0;
        end
    end

    assign head     = q_reg[rd_reg];
    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {6'd0, head.code};
    assign m_tlast  = head.last;
    // room for the largest burst one item can cause
    assign room     = (cnt_reg <= tbpc_pkg::QCNT_W'(tbpc_pkg::QDEPTH - 2));
    assign wr_plus  = tbpc_pkg::QPTR_W'(wr_reg + 1'b1);

    always_comb begin
        wr_next  = tbpc_pkg::QPTR_W'(wr_reg + n_items);
        rd_next  = pop ? tbpc_pkg::QPTR_W'(rd_reg + 1'b1) : rd_reg;
        cnt_next = tbpc_pkg::QCNT_W'(cnt_reg + tbpc_pkg::QCNT_W'(n_items)
                                     - tbpc_pkg::QCNT_W'(pop));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (n_items != 2'd0) begin
            q_reg[wr_reg] <= item_a;
        end
        if (n_items == 2'd2) begin
            q_reg[wr_plus] <= item_b;
        end
    end

    assign lane_clash = (hit_one.short_hit && hit_one.long_hit)
                     || (hit_two.short_hit && hit_two.long_hit);
    assign grow_only  = (n_items != 2'd0) && !pop;
    assign cnt_grown  = tbpc_pkg::QCNT_W'(cnt_reg + tbpc_pkg::QCNT_W'(n_items));

    `ASSERT_NEVER(a_queue_bound, aclk, aresetn, cnt_reg > tbpc_pkg::QCNT_W'(tbpc_pkg::QDEPTH))
    `ASSERT_NEVER(a_combo_alone, aclk, aresetn, combo_hit && (any_one || any_two))
    `ASSERT_NEVER(a_one_per_lane, aclk, aresetn, lane_clash)
    `ASSERT_PROP(a_count_track, aclk, aresetn, grow_only |=> cnt_reg == $past(cnt_grown))

endmodule

`default_nettype wire

// ----- hw/rtl/two_button_press_classifier.sv -----
// top level of the two-button press classifier: config registers, two button
// lanes, the combo timer and the merging stage; depends on tbpc_pkg and the
// tbpc_lane, tbpc_combo and tbpc_merge modules
//
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   tdata: now_ms, level_one, level_two
// m_*       out  m_tvalid/m_tready   tdata: event_code; tlast: last
// cfg_*     in   cfg_wr_en           cfg_addr index, cfg_wdata value
//
// lanes and combo timer decide an item at the accepting edge
// a new item is taken every cycle while the four-entry result queue has room
// for two results; results leave at one a cycle while m_tready is high, so the queue
// sets the rate when polls keep producing two results
// reset is synchronous and active low; no clearing pass is needed
// a stall on the result side fills the queue and then holds back input items through s_tready
`default_nettype none

module two_button_press_classifier #(
    parameter int TIME_BITS = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    // input items
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,    // [31:0] now_ms, [32] level_one, [33] level_two
    // result items
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,    // [1:0] event_code
    output logic        m_tlast,
    // configuration writes
    input  wire         cfg_wr_en,
    input  wire         cfg_addr,
    input  wire  [15:0] cfg_wdata
);

    logic [tbpc_pkg::CFG_W-1:0] debounce_reg;
    logic [tbpc_pkg::CFG_W-1:0] hold_reg;

    logic                       accept;
    logic                       level_one;
    logic                       level_two;
    logic                       both_low;
    logic                       lane_en;
    logic                       combo_hit;
    logic [TIME_BITS-1:0]       now;
    tbpc_pkg::lane_hit_t        hit_one;
    tbpc_pkg::lane_hit_t        hit_two;

    // register writes; the two indexes cover every cfg_addr value, so the default arm is never taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= 16'd50;
            hold_reg     <= 16'd3000;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                tbpc_pkg::CFG_DEBOUNCE: debounce_reg <= cfg_wdata;
                tbpc_pkg::CFG_HOLD:     hold_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // timestamp taken modulo 2^TIME_BITS
    assign now       = TIME_BITS'(s_tdata[31:0]);
    assign level_one = s_tdata[32];
    assign level_two = s_tdata[33];
    assign accept    = s_tvalid && s_tready;
    // both raw levels low: combo poll, lanes keep their state
    assign both_low  = !level_one && !level_two;
    assign lane_en   = accept && !both_low;

    tbpc_lane #(
        .TIME_BITS (TIME_BITS)
    ) u_lane_one (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (lane_en),
        .now         (now),
        .raw         (level_one),
        .debounce_ms (debounce_reg),
        .hold_ms     (hold_reg),
        .hit         (hit_one)
    );

    tbpc_lane #(
        .TIME_BITS (TIME_BITS)
    ) u_lane_two (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (lane_en),
        .now         (now),
        .raw         (level_two),
        .debounce_ms (debounce_reg),
        .hold_ms     (hold_reg),
        .hit         (hit_two)
    );

    tbpc_combo #(
        .TIME_BITS (TIME_BITS)
    ) u_combo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (accept),
        .both_low  (both_low),
        .now       (now),
        .hold_ms   (hold_reg),
        .combo_hit (combo_hit)
    );

    // merging stage also owns the result queue and hence the input ready
    tbpc_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .combo_hit (combo_hit),
        .hit_one   (hit_one),
        .hit_two   (hit_two),
        .room      (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
